/* hdl/mtt_pkg.sv */
// Shared widths, payload offsets, outcome codes and stage bundles of the ray/triangle test.
package mtt_pkg;

    localparam int CW  = 21;            // coordinate, Q11.10
    localparam int EW  = 22;            // edge and difference vectors
    localparam int PW  = 45;            // cross product components
    localparam int DW  = 70;            // dot products
    localparam int TW  = 20;            // parallel threshold
    localparam int IW  = 16;            // vertex index
    localparam int FB  = 10;            // fraction bits
    localparam int CMW = 96;            // distance compare width
    localparam int IN_BITS  = 424;
    localparam int OUT_BITS = 8;

    localparam int OFS_ORG  = 0;
    localparam int OFS_DIR  = 63;
    localparam int OFS_A    = 126;
    localparam int OFS_B    = 189;
    localparam int OFS_C    = 252;
    localparam int OFS_NEAR = 315;
    localparam int OFS_FAR  = 336;
    localparam int OFS_IA   = 357;
    localparam int OFS_IB   = 373;
    localparam int OFS_IC   = 389;
    localparam int OFS_IGN  = 405;

    typedef enum logic [2:0] {
        OC_HIT      = 3'd0,
        OC_SKIPPED  = 3'd1,
        OC_PARALLEL = 3'd2,
        OC_U_OUT    = 3'd3,
        OC_V_OUT    = 3'd4,
        OC_T_OUT    = 3'd5
    } outcome_t;

    typedef logic [2:0][EW-1:0] vec_t;
    typedef logic [2:0][PW-1:0] cross_t;

    typedef struct packed {
        vec_t          dir;
        vec_t          e1;
        vec_t          e2;
        vec_t          tv;
        cross_t        pv;
        cross_t        qv;
        logic [CW-1:0] near_lim;
        logic [CW-1:0] far_lim;
        logic          skip;
    } front_t;

    typedef struct packed {
        logic [DW-1:0] det;
        logic [DW-1:0] un;
        logic [DW-1:0] vn;
        logic [DW-1:0] tn;
        logic [CW-1:0] near_lim;
        logic [CW-1:0] far_lim;
        logic          skip;
    } dots_t;

endpackage

/* hdl/mtt_front.sv */
// Front stages: edge vectors and vertex skip check, cross product terms, cross products.
module mtt_front
(
    input  logic                          clk,
    input  logic [2:0]                    en,
    input  logic [mtt_pkg::IN_BITS-1:0]   tdata,
    output mtt_pkg::front_t               fr
);

    localparam int CW = mtt_pkg::CW;
    localparam int EW = mtt_pkg::EW;

    // stage 1
    mtt_pkg::vec_t dir1_reg, e1_1_reg, e2_1_reg, tv1_reg;
    mtt_pkg::vec_t dir1_next, e1_1_next, e2_1_next, tv1_next;
    logic [CW-1:0] near1_reg, far1_reg;
    logic          skip1_reg, skip1_next;
    // stage 2
    mtt_pkg::vec_t dir2_reg, e1_2_reg, e2_2_reg, tv2_reg;
    logic [CW-1:0] near2_reg, far2_reg;
    logic          skip2_reg;
    logic signed [2*EW-1:0] pa_reg [2][3];
    logic signed [2*EW-1:0] pb_reg [2][3];
    logic signed [2*EW-1:0] pa_next [2][3];
    logic signed [2*EW-1:0] pb_next [2][3];
    // stage 3
    mtt_pkg::front_t fr_reg, fr_next;

    logic [CW-1:0]           o, d, a, b, c;
    logic [mtt_pkg::IW:0]    ign;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            o = tdata[mtt_pkg::OFS_ORG + k*CW +: CW];
            d = tdata[mtt_pkg::OFS_DIR + k*CW +: CW];
            a = tdata[mtt_pkg::OFS_A + k*CW +: CW];
            b = tdata[mtt_pkg::OFS_B + k*CW +: CW];
            c = tdata[mtt_pkg::OFS_C + k*CW +: CW];
            dir1_next[k] = {d[CW-1], d};
            e1_1_next[k] = {b[CW-1], b} - {a[CW-1], a};
            e2_1_next[k] = {c[CW-1], c} - {a[CW-1], a};
            tv1_next[k]  = {o[CW-1], o} - {a[CW-1], a};
        end
        ign = tdata[mtt_pkg::OFS_IGN +: mtt_pkg::IW+1];
        skip1_next = !ign[mtt_pkg::IW] &&
            ((ign[mtt_pkg::IW-1:0] == tdata[mtt_pkg::OFS_IA +: mtt_pkg::IW]) ||
             (ign[mtt_pkg::IW-1:0] == tdata[mtt_pkg::OFS_IB +: mtt_pkg::IW]) ||
             (ign[mtt_pkg::IW-1:0] == tdata[mtt_pkg::OFS_IC +: mtt_pkg::IW]));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dir1_reg  <= dir1_next;
            e1_1_reg  <= e1_1_next;
            e2_1_reg  <= e2_1_next;
            tv1_reg   <= tv1_next;
            near1_reg <= tdata[mtt_pkg::OFS_NEAR +: CW];
            far1_reg  <= tdata[mtt_pkg::OFS_FAR +: CW];
            skip1_reg <= skip1_next;
        end
    end

    // cross terms: pv = dir x e2, qv = tv x e1
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa_next[0][k] = $signed(dir1_reg[(k+1)%3]) * $signed(e2_1_reg[(k+2)%3]);
            pb_next[0][k] = $signed(dir1_reg[(k+2)%3]) * $signed(e2_1_reg[(k+1)%3]);
            pa_next[1][k] = $signed(tv1_reg[(k+1)%3]) * $signed(e1_1_reg[(k+2)%3]);
            pb_next[1][k] = $signed(tv1_reg[(k+2)%3]) * $signed(e1_1_reg[(k+1)%3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dir2_reg  <= dir1_reg;
            e1_2_reg  <= e1_1_reg;
            e2_2_reg  <= e2_1_reg;
            tv2_reg   <= tv1_reg;
            near2_reg <= near1_reg;
            far2_reg  <= far1_reg;
            skip2_reg <= skip1_reg;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
        end
    end

    always_comb
    begin
        fr_next.dir      = dir2_reg;
        fr_next.e1       = e1_2_reg;
        fr_next.e2       = e2_2_reg;
        fr_next.tv       = tv2_reg;
        fr_next.near_lim = near2_reg;
        fr_next.far_lim  = far2_reg;
        fr_next.skip     = skip2_reg;
        for (int k = 0; k < 3; k++)
        begin
            fr_next.pv[k] = {pa_reg[0][k][2*EW-1], pa_reg[0][k]}
                          - {pb_reg[0][k][2*EW-1], pb_reg[0][k]};
            fr_next.qv[k] = {pa_reg[1][k][2*EW-1], pa_reg[1][k]}
                          - {pb_reg[1][k][2*EW-1], pb_reg[1][k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            fr_reg <= fr_next;
        end
    end

    assign fr = fr_reg;

endmodule

/* hdl/mtt_dot.sv */
// Dot product stages: split partial products, then sums for det and the three numerators.
module mtt_dot
(
    input  logic            clk,
    input  logic [1:0]      en,
    input  mtt_pkg::front_t fr,
    output mtt_pkg::dots_t  dt
);

    localparam int EW = mtt_pkg::EW;
    localparam int PW = mtt_pkg::PW;
    localparam int DW = mtt_pkg::DW;
    localparam int LB = 23;             // low split of the cross operand
    localparam int HB = PW - LB;

    logic [EW-1:0] opa [4][3];
    logic [PW-1:0] opb [4][3];
    logic signed [EW+LB:0]   lo_reg  [4][3];
    logic signed [EW+HB-1:0] hi_reg  [4][3];
    logic signed [EW+LB:0]   lo_next [4][3];
    logic signed [EW+HB-1:0] hi_next [4][3];
    logic [mtt_pkg::CW-1:0]  near4_reg, far4_reg;
    logic                    skip4_reg;
    logic [DW-1:0]           sum [4];
    mtt_pkg::dots_t          dt_reg, dt_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            opa[0][k] = fr.e1[k];  opb[0][k] = fr.pv[k];   // det
            opa[1][k] = fr.tv[k];  opb[1][k] = fr.pv[k];   // u numerator
            opa[2][k] = fr.dir[k]; opb[2][k] = fr.qv[k];   // v numerator
            opa[3][k] = fr.e2[k];  opb[3][k] = fr.qv[k];   // t numerator
        end
        for (int j = 0; j < 4; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_next[j][k] = $signed(opa[j][k]) * $signed({1'b0, opb[j][k][LB-1:0]});
                hi_next[j][k] = $signed(opa[j][k]) * $signed(opb[j][k][PW-1:LB]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            near4_reg <= fr.near_lim;
            far4_reg  <= fr.far_lim;
            skip4_reg <= fr.skip;
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sum[j] = '0;
            for (int k = 0; k < 3; k++)
            begin
                sum[j] = sum[j]
                    + ({{(DW-EW-HB){hi_reg[j][k][EW+HB-1]}}, hi_reg[j][k]} << LB)
                    + {{(DW-EW-LB-1){lo_reg[j][k][EW+LB]}}, lo_reg[j][k]};
            end
        end
        dt_next.det      = sum[0];
        dt_next.un       = sum[1];
        dt_next.vn       = sum[2];
        dt_next.tn       = sum[3];
        dt_next.near_lim = near4_reg;
        dt_next.far_lim  = far4_reg;
        dt_next.skip     = skip4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dt_reg <= dt_next;
        end
    end

    assign dt = dt_reg;

endmodule

/* hdl/mtt_test.sv */
// Decision stages: sign normalize and range checks, distance products, distance window test.
module mtt_test
(
    input  logic                      clk,
    input  logic [2:0]                en,
    input  logic [mtt_pkg::TW-1:0]    thr,
    input  mtt_pkg::dots_t            dt,
    output logic                      hit,
    output mtt_pkg::outcome_t         outcome
);

    localparam int CW  = mtt_pkg::CW;
    localparam int DW  = mtt_pkg::DW;
    localparam int CMW = mtt_pkg::CMW;
    localparam int SB  = 24;            // split of |det| for the distance products

    // stage 6
    logic [DW-1:0]     dmag, un_n, vn_n, tn_n;
    logic [DW:0]       uv_sum;
    logic              neg, par, u_bad, v_bad;
    mtt_pkg::outcome_t oc6_next, oc6_reg;
    logic [DW-1:0]     dmag6_reg, tn6_reg;
    logic [CW-1:0]     near6_reg, far6_reg;
    // stage 7
    logic signed [CW+SB:0] pn_reg [3];
    logic signed [CW+SB:0] pf_reg [3];
    logic signed [CW+SB:0] pn_next [3];
    logic signed [CW+SB:0] pf_next [3];
    logic [SB-1:0]         piece [3];
    logic [CMW-1:0]        lhs7_reg;
    mtt_pkg::outcome_t     oc7_reg;
    // stage 8
    logic [CMW-1:0]        rn, rf;
    mtt_pkg::outcome_t     oc8_next, oc8_reg;

    always_comb
    begin
        neg    = dt.det[DW-1];
        dmag   = neg ? (DW'(0) - dt.det) : dt.det;
        un_n   = neg ? (DW'(0) - dt.un)  : dt.un;
        vn_n   = neg ? (DW'(0) - dt.vn)  : dt.vn;
        tn_n   = neg ? (DW'(0) - dt.tn)  : dt.tn;
        uv_sum = {un_n[DW-1], un_n} + {vn_n[DW-1], vn_n};
        par    = dmag < {{(DW-mtt_pkg::TW){1'b0}}, thr};
        u_bad  = un_n[DW-1] || ($signed(un_n) > $signed(dmag));
        v_bad  = vn_n[DW-1] || ($signed(uv_sum) > $signed({1'b0, dmag}));
        if (dt.skip)
            oc6_next = mtt_pkg::OC_SKIPPED;
        else if (par)
            oc6_next = mtt_pkg::OC_PARALLEL;
        else if (u_bad)
            oc6_next = mtt_pkg::OC_U_OUT;
        else if (v_bad)
            oc6_next = mtt_pkg::OC_V_OUT;
        else
            oc6_next = mtt_pkg::OC_HIT;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            oc6_reg   <= oc6_next;
            dmag6_reg <= dmag;
            tn6_reg   <= tn_n;
            near6_reg <= dt.near_lim;
            far6_reg  <= dt.far_lim;
        end
    end

    always_comb
    begin
        piece[0] = dmag6_reg[SB-1:0];
        piece[1] = dmag6_reg[2*SB-1:SB];
        piece[2] = {{(3*SB-DW){1'b0}}, dmag6_reg[DW-1:2*SB]};
        for (int j = 0; j < 3; j++)
        begin
            pn_next[j] = $signed(near6_reg) * $signed({1'b0, piece[j]});
            pf_next[j] = $signed(far6_reg) * $signed({1'b0, piece[j]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pn_reg   <= pn_next;
            pf_reg   <= pf_next;
            lhs7_reg <= {{(CMW-DW){tn6_reg[DW-1]}}, tn6_reg} << mtt_pkg::FB;
            oc7_reg  <= oc6_reg;
        end
    end

    always_comb
    begin
        rn = '0;
        rf = '0;
        for (int j = 0; j < 3; j++)
        begin
            rn = rn + ({{(CMW-CW-SB-1){pn_reg[j][CW+SB]}}, pn_reg[j]} << (j*SB));
            rf = rf + ({{(CMW-CW-SB-1){pf_reg[j][CW+SB]}}, pf_reg[j]} << (j*SB));
        end
        if (oc7_reg != mtt_pkg::OC_HIT)
            oc8_next = oc7_reg;
        else if (($signed(lhs7_reg) <= $signed(rn)) || ($signed(lhs7_reg) >= $signed(rf)))
            oc8_next = mtt_pkg::OC_T_OUT;
        else
            oc8_next = mtt_pkg::OC_HIT;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            oc8_reg <= oc8_next;
        end
    end

    assign outcome = oc8_reg;
    assign hit     = (oc8_reg == mtt_pkg::OC_HIT);

endmodule

/* hdl/ray_triangle_occlusion_test_unit.sv */
// Top level of the pipelined double-sided ray/triangle occlusion test.
// One ray/triangle pair enters per transfer on the s_ side and one verdict leaves per
// transfer on the m_ side, in order. The unit is an eight-stage pipeline: edge vectors
// and the vertex skip compare, cross product terms, cross products, split dot product
// terms, dot sums, sign normalization with the parallel/u/v checks, distance products,
// and the distance window compare that loads the output register. It takes a new pair
// every cycle unless m_tready back-pressure fills the pipeline; m_tvalid rises once
// the verdict is in the output register. Every stage has its own valid bit and
// advances when it is empty or the stage after it advances, so a stalled output
// holds only what is full and bubbles still close up behind it. The comparisons
// are exact integer compares against the sign-normalized determinant, so no divider
// is involved. parallel_threshold resets to 1 (only a zero determinant is parallel)
// and the user writes it via cfg_we/cfg_wdata only while idle; the unit does not check.
module ray_triangle_occlusion_test_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    // config
    input  logic                           cfg_we,
    input  logic [mtt_pkg::TW-1:0]         cfg_wdata,   // parallel_threshold
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ray_origin, ray_direction, corner_a, corner_b, corner_c, near_limit, far_limit,
    // index_a, index_b, index_c, ignored_vertex, zero pad
    input  logic [mtt_pkg::IN_BITS-1:0]    s_tdata,
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mtt_pkg::OUT_BITS-1:0]   m_tdata      // hit, outcome[2:0], zero pad
);

    localparam int NS = 8;

    logic [mtt_pkg::TW-1:0] thr_reg;
    logic [NS-1:0]          vld_reg;
    logic [NS-1:0]          en;
    mtt_pkg::front_t        fr;
    mtt_pkg::dots_t         dt;
    logic                   hit;
    mtt_pkg::outcome_t      outcome;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= mtt_pkg::TW'(1);
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // per-stage advance: a stage moves when empty or when its successor moves
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int i = NS-2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    mtt_front u_front
    (
        .clk   (clk),
        .en    (en[2:0]),
        .tdata (s_tdata),
        .fr    (fr)
    );

    mtt_dot u_dot
    (
        .clk (clk),
        .en  (en[4:3]),
        .fr  (fr),
        .dt  (dt)
    );

    mtt_test u_test
    (
        .clk     (clk),
        .en      (en[7:5]),
        .thr     (thr_reg),
        .dt      (dt),
        .hit     (hit),
        .outcome (outcome)
    );

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {{(mtt_pkg::OUT_BITS-4){1'b0}}, outcome, hit};

endmodule
